[design/qco_pkg.sv]
// shared constants and types for the quad/circle overlap test
`timescale 1ns / 1ps
`default_nettype none

package qco_pkg;

    // default coordinate width
    localparam int COORD_BITS_DEF = 16;
    // input fields in the request: four corners, centre, radius
    localparam int NUM_FIELDS = 11;
    localparam int NUM_EDGES  = 4;

    // result bit positions in the output tdata
    localparam int RES_OVERLAP = 0;
    localparam int RES_EDGE    = 1;
    localparam int RES_INSIDE  = 2;
    localparam int RES_BITS    = 3;

    // per-edge outcome handed from a lane to the top level
    typedef struct packed {
        logic hit;  // edge or its start corner meets the circle
        logic pos;  // centre strictly left of the edge
        logic neg;  // centre strictly right of the edge
    } t_lane_res;

endpackage

`default_nettype wire

[design/qco_wmul.sv]
// wide unsigned multiplier split into half-width partial products over two stages
`timescale 1ns / 1ps
`default_nettype none

module qco_wmul #(
    parameter int W = 34
) (
    input  wire logic             i_clk,
    input  wire logic             i_en_a,
    input  wire logic             i_en_b,
    input  wire logic [W-1:0]     i_a,
    input  wire logic [W-1:0]     i_b,
    output      logic [2*W-1:0]   o_p
);

    localparam int H  = (W + 1) / 2;
    localparam int L  = W - H;
    localparam int P2 = 2 * W;

    logic [2*H-1:0] r_ll;
    logic [H+L-1:0] r_lh;
    logic [H+L-1:0] r_hl;
    logic [2*L-1:0] r_hh;
    logic [P2-1:0]  r_p;
    logic [P2-1:0]  n_p;

    // partial products
    always_ff @(posedge i_clk) begin
        if (i_en_a) begin
            r_ll <= i_a[H-1:0] * i_b[H-1:0];
            r_lh <= i_a[H-1:0] * i_b[W-1:H];
            r_hl <= i_a[W-1:H] * i_b[H-1:0];
            r_hh <= i_a[W-1:H] * i_b[W-1:H];
        end
    end

    always_comb begin
        n_p = (P2'(r_hh) << (2 * H))
            + ((P2'(r_lh) + P2'(r_hl)) << H)
            + P2'(r_ll);
    end

    always_ff @(posedge i_clk) begin
        if (i_en_b) begin
            r_p <= n_p;
        end
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

[design/qco_lane.sv]
// one edge lane: differences, products, sums, exact squared-distance compares
`timescale 1ns / 1ps
`default_nettype none

module qco_lane #(
    parameter int CW = qco_pkg::COORD_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic [5:0]        i_en,
    input  wire logic [CW-1:0]     i_ax,
    input  wire logic [CW-1:0]     i_ay,
    input  wire logic [CW-1:0]     i_bx,
    input  wire logic [CW-1:0]     i_by,
    input  wire logic [CW-1:0]     i_cx,
    input  wire logic [CW-1:0]     i_cy,
    input  wire logic [CW-1:0]     i_r,
    output qco_pkg::t_lane_res     o_res
);

    localparam int DW = CW + 1;
    localparam int PW = 2 * DW;

    localparam int F_VIN  = 0;
    localparam int F_PROJ = 1;
    localparam int F_POS  = 2;
    localparam int F_NEG  = 3;

    // stage 1: edge vector d and centre offset e
    logic signed [DW-1:0] r_dx, r_dy, r_ex, r_ey;
    logic        [CW-1:0] r_r1;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_dx <= {i_bx[CW-1], i_bx} - {i_ax[CW-1], i_ax};
            r_dy <= {i_by[CW-1], i_by} - {i_ay[CW-1], i_ay};
            r_ex <= {i_cx[CW-1], i_cx} - {i_ax[CW-1], i_ax};
            r_ey <= {i_cy[CW-1], i_cy} - {i_ay[CW-1], i_ay};
            r_r1 <= i_r;
        end
    end

    // stage 2: products
    logic signed [PW-1:0] r_pxy, r_pyx, r_pdx, r_pdy, r_dxx, r_dyy, r_exx, r_eyy;
    logic        [2*CW-1:0] r_r2;

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_pxy <= r_dx * r_ey;
            r_pyx <= r_dy * r_ex;
            r_pdx <= r_ex * r_dx;
            r_pdy <= r_ey * r_dy;
            r_dxx <= r_dx * r_dx;
            r_dyy <= r_dy * r_dy;
            r_exx <= r_ex * r_ex;
            r_eyy <= r_ey * r_ey;
            r_r2  <= r_r1 * r_r1;
        end
    end

    // stage 3: cross, dot, squared lengths
    logic signed [PW:0]   r_cr, r_dt;
    logic        [PW-1:0] r_len2, r_pd2;
    logic        [2*CW-1:0] r_r2b;

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_cr   <= {r_pxy[PW-1], r_pxy} - {r_pyx[PW-1], r_pyx};
            r_dt   <= {r_pdx[PW-1], r_pdx} + {r_pdy[PW-1], r_pdy};
            r_len2 <= $unsigned(r_dxx) + $unsigned(r_dyy);
            r_pd2  <= $unsigned(r_exx) + $unsigned(r_eyy);
            r_r2b  <= r_r2;
        end
    end

    // stage 4: corner-in-circle, projection window, cross magnitude and sign
    logic [PW:0]   n_cneg;
    logic [PW-1:0] n_cmag;
    logic [3:0]    n_flags;
    logic [PW-1:0] r_cmag, r_len2b, r_r2w;
    logic [3:0]    r_f4, r_f5, r_f6;

    always_comb begin
        n_cneg = '0 - r_cr;
        n_cmag = r_cr[PW] ? n_cneg[PW-1:0] : r_cr[PW-1:0];
        n_flags[F_VIN]  = r_pd2 < {2'b00, r_r2b};
        n_flags[F_PROJ] = !r_dt[PW] && (r_dt != '0) && (r_dt[PW-1:0] < r_len2);
        n_flags[F_POS]  = !r_cr[PW] && (r_cr != '0);
        n_flags[F_NEG]  = r_cr[PW];
    end

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_cmag  <= n_cmag;
            r_len2b <= r_len2;
            r_r2w   <= {2'b00, r_r2b};
            r_f4    <= n_flags;
        end
    end

    // stages 5 and 6: cross^2 against r^2 * |d|^2
    logic [2*PW-1:0] w_sq, w_rl;

    qco_wmul #(.W(PW)) u_sq (
        .i_clk  (i_clk),
        .i_en_a (i_en[4]),
        .i_en_b (i_en[5]),
        .i_a    (r_cmag),
        .i_b    (r_cmag),
        .o_p    (w_sq)
    );

    qco_wmul #(.W(PW)) u_rl (
        .i_clk  (i_clk),
        .i_en_a (i_en[4]),
        .i_en_b (i_en[5]),
        .i_a    (r_r2w),
        .i_b    (r_len2b),
        .o_p    (w_rl)
    );

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r_f5 <= r_f4;
        end
        if (i_en[5]) begin
            r_f6 <= r_f5;
        end
    end

    always_comb begin
        o_res.hit = r_f6[F_VIN] | (r_f6[F_PROJ] & (w_sq < w_rl));
        o_res.pos = r_f6[F_POS];
        o_res.neg = r_f6[F_NEG];
    end

endmodule

`default_nettype wire

[design/quad_circle_overlap_test.sv]
// quad_circle_overlap_test: streaming quadrilateral / circle overlap decision
// each request passes through the lane stages and the output register before o_m_axis_tvalid
// throughput: one request per cycle while the output is not stalled, set by the fully pipelined edge lanes
// a stalled output fills bubbles first, so requests are taken until every stage holds one
// reset: synchronous, active low; clears all stage valid bits and the output valid
`timescale 1ns / 1ps
`default_nettype none

module quad_circle_overlap_test #(
    parameter int COORD_BITS = qco_pkg::COORD_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    // request side
    input  wire logic i_s_axis_tvalid,
    output      logic o_s_axis_tready,
    // tdata, lowest bit up, COORD_BITS each: vertex0_x, vertex0_y, vertex1_x, vertex1_y,
    // vertex2_x, vertex2_y, vertex3_x, vertex3_y, center_x, center_y, radius, zero pad
    input  wire logic [((qco_pkg::NUM_FIELDS*COORD_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    // result side
    output      logic       o_m_axis_tvalid,
    input  wire logic       i_m_axis_tready,
    // tdata, lowest bit up: overlap, edge_hit, center_inside, zero pad
    output      logic [7:0] o_m_axis_tdata
);

    localparam int CW     = COORD_BITS;
    localparam int NE     = qco_pkg::NUM_EDGES;
    localparam int STAGES = 6;

    // field slices of the request word
    logic [CW-1:0] w_vx [NE];
    logic [CW-1:0] w_vy [NE];
    logic [CW-1:0] w_cx, w_cy, w_r;

    always_comb begin
        for (int k = 0; k < NE; k++) begin
            w_vx[k] = i_s_axis_tdata[(2*k)*CW +: CW];
            w_vy[k] = i_s_axis_tdata[(2*k+1)*CW +: CW];
        end
        w_cx = i_s_axis_tdata[(2*NE)*CW +: CW];
        w_cy = i_s_axis_tdata[(2*NE+1)*CW +: CW];
        w_r  = i_s_axis_tdata[(2*NE+2)*CW +: CW];
    end

    // pipeline control: a stage may load when it is empty or the next one can load
    logic [STAGES:1]   r_v;
    logic              r_ov;
    logic [STAGES+1:1] w_rdy;

    always_comb begin
        w_rdy[STAGES+1] = !r_ov || i_m_axis_tready;
        for (int k = STAGES; k >= 1; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end

    assign o_s_axis_tready = w_rdy[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_ov <= 1'b0;
        end else begin
            if (w_rdy[1]) begin
                r_v[1] <= i_s_axis_tvalid;
            end
            for (int k = 2; k <= STAGES; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
            if (w_rdy[STAGES+1]) begin
                r_ov <= r_v[STAGES];
            end
        end
    end

    // one lane per edge, edge i runs from corner i to corner (i+1) mod 4
    qco_pkg::t_lane_res w_res [NE];

    genvar g;
    generate
        for (g = 0; g < NE; g++) begin : g_lane
            localparam int J = (g + 1) % NE;
            qco_lane #(.CW(CW)) u_lane (
                .i_clk (i_clk),
                .i_en  (w_rdy[STAGES:1]),
                .i_ax  (w_vx[g]),
                .i_ay  (w_vy[g]),
                .i_bx  (w_vx[J]),
                .i_by  (w_vy[J]),
                .i_cx  (w_cx),
                .i_cy  (w_cy),
                .i_r   (w_r),
                .o_res (w_res[g])
            );
        end
    endgenerate

    // combine: any edge hit, and centre inside unless an edge disagrees with edge 0
    logic                          n_hit, n_pos_any, n_neg_any, n_inside;
    logic [qco_pkg::RES_BITS-1:0]  n_out;
    logic [qco_pkg::RES_BITS-1:0]  r_out;

    always_comb begin
        n_hit     = 1'b0;
        n_pos_any = 1'b0;
        n_neg_any = 1'b0;
        for (int k = 0; k < NE; k++) begin
            n_hit = n_hit | w_res[k].hit;
        end
        for (int k = 1; k < NE; k++) begin
            n_pos_any = n_pos_any | w_res[k].pos;
            n_neg_any = n_neg_any | w_res[k].neg;
        end
        // a zero cross product never disagrees
        n_inside = !((w_res[0].pos && n_neg_any) || (w_res[0].neg && n_pos_any));
        n_out[qco_pkg::RES_OVERLAP] = n_hit | n_inside;
        n_out[qco_pkg::RES_EDGE]    = n_hit;
        n_out[qco_pkg::RES_INSIDE]  = n_inside;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (w_rdy[STAGES+1]) begin
            r_out <= n_out;
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = {{(8-qco_pkg::RES_BITS){1'b0}}, r_out};

endmodule

`default_nettype wire
